// ===== hw/rtl/fesu_pkg.sv =====
package fesu_pkg;

    // Geometry defaults and fixed field widths.
    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 128;
    localparam int LEVEL_W         = 5;
    localparam int OP_W            = 2;
    localparam int COL_IN_W        = 5;
    localparam int ROW_IN_W        = 7;
    localparam int CFG_INDEX_W     = 2;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] IGNITE_LEVEL_RST  = LEVEL_W'(23);
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR_RST   = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_CEILING_RST = LEVEL_W'(7);
    localparam logic [LEVEL_W-1:0] CLEAR_LEVEL       = LEVEL_W'(1);

    // Stencil arithmetic. Eleven levels of at most 31 sum to at most 341.
    // floor(sum / 11) equals (sum * 745) >> 13 exactly over that range.
    localparam int NEIGHBOUR_COUNT = 11;
    localparam int SUM_W           = 9;
    localparam int DIV_MULT_W      = 10;
    localparam int PROD_W          = SUM_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(745);
    localparam int DIV_SHIFT       = 13;

    // Sliding windows: the center column trails the column being read by three.
    localparam int CUR_TAPS   = 5;
    localparam int ABOVE_TAPS = 4;
    localparam int BELOW_TAPS = 3;
    localparam int CENTER_LAG = 3;
    localparam int EDGE_COLS  = 2;
    localparam int UPD_FIRST  = CENTER_LAG + EDGE_COLS;

    // Ignition cross, one cell per cycle.
    localparam int CROSS_W = 3;
    localparam logic [CROSS_W-1:0] CROSS_CENTER = CROSS_W'(0);
    localparam logic [CROSS_W-1:0] CROSS_EAST   = CROSS_W'(1);
    localparam logic [CROSS_W-1:0] CROSS_WEST   = CROSS_W'(2);
    localparam logic [CROSS_W-1:0] CROSS_SOUTH  = CROSS_W'(3);
    localparam logic [CROSS_W-1:0] CROSS_NORTH  = CROSS_W'(4);
    localparam logic [CROSS_W-1:0] CROSS_LAST   = CROSS_NORTH;

    typedef enum logic [OP_W-1:0] {
        OP_IGNITE = 2'd0,
        OP_PASS   = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IGNITE_LEVEL  = 2'd0,
        CFG_LEVEL_FLOOR   = 2'd1,
        CFG_LEVEL_CEILING = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IGNITE,
        ST_READ,
        ST_PASS_A,
        ST_PASS_B,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic cross_wr;
        logic read_cell;
        logic pass_a;
        logic pass_b;
        logic load_result;
    } fesu_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cross_last;
        logic step_last;
        logic row_last;
    } fesu_status_t;

endpackage

// ===== hw/rtl/fire_effect_stencil_update_unit.sv =====
// Fire-effect heat grid with an in-place averaging flicker pass.
// Input words (s_valid/s_ready) carry an op, a column and a row: op 0 ignites a
// plus-shaped cross, op 1 runs one flicker pass, op 2 reads one cell. Every
// input word yields exactly one result word (m_valid/m_ready) carrying
// m_cell_level, the level read for an in-range op 2 and zero otherwise. The
// three level registers are written through cfg_wr_en/cfg_index/cfg_wdata,
// which the user must do only while idle; the block itself does not enforce it.
// A pass walks each row one column per step, each step split into phases A
// and B, as the grid memory has two read ports and a step needs three reads.
// One word is in flight at a time; the next is taken once the result has
// moved into the output register, even if the receiver has not taken it.
// After reset the grid memory is swept to level 1, one cell per cycle, over all
// GRID_HEIGHT*2^clog2(GRID_WIDTH) cells (4096 by default); s_ready stays low
// meanwhile, and configuration writes are taken as usual. While the receiver
// stalls, the result word holds and the block waits before loading another.
module fire_effect_stencil_update_unit
    import fesu_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_op,
    input  logic [COL_IN_W-1:0]    s_col,
    input  logic [ROW_IN_W-1:0]    s_row,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEVEL_W-1:0]     m_cell_level,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_wdata
);

    fesu_cmd_t    cmd;
    fesu_status_t status;

    fesu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    fesu_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_op         (s_op),
        .s_col        (s_col),
        .s_row        (s_row),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_cell_level (m_cell_level)
    );

endmodule

// ===== hw/rtl/fesu_ctrl.sv =====
module fesu_ctrl
    import fesu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [OP_W-1:0]    s_op,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output fesu_cmd_t          cmd,
    input  fesu_status_t       status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_IGNITE: state_next = ST_IGNITE;
                        OP_PASS:   state_next = ST_PASS_A;
                        OP_READ:   state_next = ST_READ;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_IGNITE: begin
                if (status.cross_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ: begin
                state_next = ST_FINISH;
            end
            ST_PASS_A: begin
                state_next = ST_PASS_B;
            end
            ST_PASS_B: begin
                if (status.step_last && status.row_last) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_PASS_A;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_IGNITE: begin
                cmd.cross_wr = 1'b1;
            end
            ST_READ: begin
                cmd.read_cell = 1'b1;
            end
            ST_PASS_A: begin
                cmd.pass_a = 1'b1;
            end
            ST_PASS_B: begin
                cmd.pass_b = 1'b1;
            end
            ST_FINISH: begin
                cmd.load_result = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/fesu_datapath.sv =====
module fesu_datapath
    import fesu_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fesu_cmd_t              cmd,
    output fesu_status_t           status,
    input  logic [OP_W-1:0]        s_op,
    input  logic [COL_IN_W-1:0]    s_col,
    input  logic [ROW_IN_W-1:0]    s_row,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_wdata,
    output logic [LEVEL_W-1:0]     m_cell_level
);

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = GRID_HEIGHT * (2 ** COL_W);
    localparam int STEP_W = $clog2(GRID_WIDTH + 1);
    localparam int TROW_W = ((ROW_IN_W > ROW_W) ? ROW_IN_W : ROW_W) + 2;
    localparam int TCOL_W = ((COL_IN_W > COL_W) ? COL_IN_W : COL_W) + 2;

    // Heat grid: one write port, two registered read ports.
    logic [LEVEL_W-1:0] mem [DEPTH];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [LEVEL_W-1:0] mem_wdata;
    logic               mem_re0;
    logic               mem_re1;
    logic [ADDR_W-1:0]  mem_raddr0;
    logic [ADDR_W-1:0]  mem_raddr1;
    logic [LEVEL_W-1:0] rd0_reg;
    logic [LEVEL_W-1:0] rd1_reg;

    // Configuration.
    logic [LEVEL_W-1:0] ignite_level_reg, ignite_level_next;
    logic [LEVEL_W-1:0] level_floor_reg, level_floor_next;
    logic [LEVEL_W-1:0] level_ceiling_reg, level_ceiling_next;

    // Captured input word.
    logic [OP_W-1:0]     in_op_reg, in_op_next;
    logic [COL_IN_W-1:0] in_col_reg, in_col_next;
    logic [ROW_IN_W-1:0] in_row_reg, in_row_next;

    // Sequencing counters.
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CROSS_W-1:0] cross_idx_reg, cross_idx_next;
    logic [ROW_W-1:0]   pass_row_reg, pass_row_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // Stencil windows and arithmetic.
    logic [LEVEL_W-1:0] cur_win_reg [CUR_TAPS];
    logic [LEVEL_W-1:0] cur_win_next [CUR_TAPS];
    logic [LEVEL_W-1:0] above_win_reg [ABOVE_TAPS];
    logic [LEVEL_W-1:0] above_win_next [ABOVE_TAPS];
    logic [LEVEL_W-1:0] below_win_reg [BELOW_TAPS];
    logic [LEVEL_W-1:0] below_win_next [BELOW_TAPS];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] avg_level;
    logic [LEVEL_W-1:0] floored_level;
    logic [LEVEL_W-1:0] new_level;
    logic               upd_en;

    logic [LEVEL_W-1:0] result_reg, result_next;

    // Addressing.
    logic [TROW_W-1:0] row_ofs;
    logic [TCOL_W-1:0] col_ofs;
    logic [TROW_W-1:0] tgt_row;
    logic [TCOL_W-1:0] tgt_col;
    logic              tgt_in_range;
    logic [ADDR_W-1:0] tgt_addr;
    logic [ROW_W-1:0]  row_up;
    logic [ROW_W-1:0]  row_dn;
    logic [COL_W-1:0]  step_col;
    logic [STEP_W-1:0] upd_step;
    logic [COL_W-1:0]  upd_col;

    always_comb begin
        row_ofs = '0;
        col_ofs = '0;
        case (cross_idx_reg)
            CROSS_CENTER: begin
                row_ofs = '0;
                col_ofs = '0;
            end
            CROSS_EAST:  col_ofs = TCOL_W'(1);
            CROSS_WEST:  col_ofs = '1;
            CROSS_SOUTH: row_ofs = TROW_W'(1);
            CROSS_NORTH: row_ofs = '1;
            default: begin
                row_ofs = '0;
                col_ofs = '0;
            end
        endcase
    end

    // A negative offset past the edge sets the top bit, which reads as out of range.
    assign tgt_row = TROW_W'(in_row_reg) + row_ofs;
    assign tgt_col = TCOL_W'(in_col_reg) + col_ofs;
    assign tgt_in_range = !tgt_row[TROW_W-1] && (tgt_row < TROW_W'(GRID_HEIGHT))
                        && !tgt_col[TCOL_W-1] && (tgt_col < TCOL_W'(GRID_WIDTH));
    assign tgt_addr = {tgt_row[ROW_W-1:0], tgt_col[COL_W-1:0]};

    assign row_up   = pass_row_reg - ROW_W'(1);
    assign row_dn   = pass_row_reg + ROW_W'(1);
    assign step_col = step_reg[COL_W-1:0];
    assign upd_step = step_reg - STEP_W'(CENTER_LAG);
    assign upd_col  = upd_step[COL_W-1:0];

    // Average, clamp, and keep the larger of it and the cell one row up.
    assign prod      = PROD_W'(sum_reg) * PROD_W'(DIV_MULT);
    assign avg_level = prod[DIV_SHIFT +: LEVEL_W];
    assign floored_level = (avg_level < level_floor_reg) ? level_floor_reg : avg_level;
    assign new_level = (floored_level > level_ceiling_reg) ? level_ceiling_reg : floored_level;
    assign upd_en    = (step_reg >= STEP_W'(UPD_FIRST)) && (new_level > above_win_reg[1]);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = CLEAR_LEVEL;
        if (cmd.clear_wr) begin
            mem_we = 1'b1;
        end else if (cmd.cross_wr) begin
            mem_we    = tgt_in_range;
            mem_waddr = tgt_addr;
            mem_wdata = ignite_level_reg;
        end else if (cmd.pass_b) begin
            mem_we    = upd_en;
            mem_waddr = {row_up, upd_col};
            mem_wdata = new_level;
        end
    end

    // Phase A reads the row above and the center row, phase B the row below.
    assign mem_re0    = cmd.read_cell || cmd.pass_a;
    assign mem_raddr0 = cmd.read_cell ? tgt_addr : {row_up, step_col};
    assign mem_re1    = cmd.pass_a || cmd.pass_b;
    assign mem_raddr1 = cmd.pass_a ? {pass_row_reg, step_col} : {row_dn, step_col};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re0) begin
            rd0_reg <= mem[mem_raddr0];
        end
        if (mem_re1) begin
            rd1_reg <= mem[mem_raddr1];
        end
    end

    always_comb begin
        ignite_level_next  = ignite_level_reg;
        level_floor_next   = level_floor_reg;
        level_ceiling_next = level_ceiling_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IGNITE_LEVEL:  ignite_level_next  = cfg_wdata;
                CFG_LEVEL_FLOOR:   level_floor_next   = cfg_wdata;
                CFG_LEVEL_CEILING: level_ceiling_next = cfg_wdata;
                default: begin
                    ignite_level_next = ignite_level_reg;
                end
            endcase
        end
    end

    always_comb begin
        in_op_next     = in_op_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        clr_addr_next  = clr_addr_reg;
        cross_idx_next = cross_idx_reg;
        pass_row_next  = pass_row_reg;
        step_next      = step_reg;
        if (cmd.capture) begin
            in_op_next     = s_op;
            in_col_next    = s_col;
            in_row_next    = s_row;
            cross_idx_next = CROSS_CENTER;
            pass_row_next  = ROW_W'(GRID_HEIGHT - 2);
            step_next      = '0;
        end
        if (cmd.clear_wr) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
        if (cmd.cross_wr) begin
            cross_idx_next = cross_idx_reg + CROSS_W'(1);
        end
        if (cmd.pass_b) begin
            if (status.step_last) begin
                step_next     = '0;
                pass_row_next = row_up;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // The windows shift by one column per step. The center cell one row up is
    // replaced by its new value before it moves left, so the next cell sees it.
    always_comb begin
        cur_win_next   = cur_win_reg;
        above_win_next = above_win_reg;
        below_win_next = below_win_reg;
        sum_next       = sum_reg;
        if (cmd.pass_a) begin
            sum_next = SUM_W'(cur_win_reg[0]) + SUM_W'(cur_win_reg[1])
                     + SUM_W'(cur_win_reg[2]) + SUM_W'(cur_win_reg[3])
                     + SUM_W'(cur_win_reg[4])
                     + SUM_W'(above_win_reg[0]) + SUM_W'(above_win_reg[1])
                     + SUM_W'(above_win_reg[2])
                     + SUM_W'(below_win_reg[0]) + SUM_W'(below_win_reg[1])
                     + SUM_W'(below_win_reg[2]);
            for (int i = 0; i < BELOW_TAPS - 1; i++) begin
                below_win_next[i] = below_win_reg[i+1];
            end
            below_win_next[BELOW_TAPS-1] = rd1_reg;
        end
        if (cmd.pass_b) begin
            for (int i = 0; i < CUR_TAPS - 1; i++) begin
                cur_win_next[i] = cur_win_reg[i+1];
            end
            cur_win_next[CUR_TAPS-1] = rd1_reg;
            above_win_next[0] = upd_en ? new_level : above_win_reg[1];
            for (int i = 1; i < ABOVE_TAPS - 1; i++) begin
                above_win_next[i] = above_win_reg[i+1];
            end
            above_win_next[ABOVE_TAPS-1] = rd0_reg;
        end
    end

    always_comb begin
        result_next = result_reg;
        if (cmd.load_result) begin
            result_next = (in_op_reg == OP_READ && tgt_in_range) ? rd0_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignite_level_reg  <= IGNITE_LEVEL_RST;
            level_floor_reg   <= LEVEL_FLOOR_RST;
            level_ceiling_reg <= LEVEL_CEILING_RST;
            clr_addr_reg      <= '0;
            cross_idx_reg     <= CROSS_CENTER;
            pass_row_reg      <= '0;
            step_reg          <= '0;
        end else begin
            ignite_level_reg  <= ignite_level_next;
            level_floor_reg   <= level_floor_next;
            level_ceiling_reg <= level_ceiling_next;
            clr_addr_reg      <= clr_addr_next;
            cross_idx_reg     <= cross_idx_next;
            pass_row_reg      <= pass_row_next;
            step_reg          <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_op_reg     <= in_op_next;
        in_col_reg    <= in_col_next;
        in_row_reg    <= in_row_next;
        cur_win_reg   <= cur_win_next;
        above_win_reg <= above_win_next;
        below_win_reg <= below_win_next;
        sum_reg       <= sum_next;
        result_reg    <= result_next;
    end

    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign status.cross_last = (cross_idx_reg == CROSS_LAST);
    assign status.step_last  = (step_reg == STEP_W'(GRID_WIDTH));
    assign status.row_last   = (pass_row_reg == ROW_W'(1));

    assign m_cell_level = result_reg;

endmodule
